### design/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define GTBP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// one-hot-or-zero check
`define GTBP_ASSERT_ONEHOT0(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(sig)) else $error(msg);
`endif

### design/gtbp_pkg.sv
// ----------------------------------------------------------------------------
// gtbp_pkg
// types and constants shared by the block pool modules
// ----------------------------------------------------------------------------
package gtbp_pkg;
  localparam int unsigned MaxBlocks    = 256;
  localparam int unsigned MaxBlockBytes = 4096;
  localparam int unsigned IdxW  = $clog2(MaxBlocks);
  localparam int unsigned CntW  = $clog2(MaxBlocks + 1);
  localparam int unsigned OffW  = 24;
  localparam int unsigned QuoW  = 24;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_RETIRE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SIZE      = 3'd1,
    ST_ALIGN     = 3'd2,
    ST_BAD_ADDR  = 3'd3,
    ST_DBL_FREE  = 3'd4
  } status_e;

  localparam logic CfgBlockSize  = 1'b0;
  localparam logic CfgBlockCount = 1'b1;

  // divider handshake
  typedef struct packed {
    logic            start;
    logic [OffW-1:0] dividend;
    logic [12:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [QuoW-1:0] quotient;
    logic            rem_zero;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_AREAD, S_AWAIT, S_AGEN, S_DIV, S_FREAD, S_FWAIT,
    S_FUPD, S_RETIRE, S_RWAIT, S_DONE
  } state_e;
endpackage

### design/gtbp_divider.sv
// ----------------------------------------------------------------------------
// gtbp_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gtbp_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gtbp_pkg::div_req_t req_i,
  output gtbp_pkg::div_rsp_t rsp_o
);
  import gtbp_pkg::*;

  logic [QuoW-1:0] quo_q, quo_d;
  logic [13:0]     rem_q, rem_d;
  logic [12:0]     dvs_q, dvs_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            run_q, run_d, done_q, done_d;
  logic [13:0]     trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = '0;
    if (req_i.start) begin
      quo_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
      cnt_d = 5'(QuoW);
      run_d = 1'b1;
    end else if (run_q) begin
      trial = {rem_q[12:0], quo_q[QuoW-1]};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[QuoW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
  assign rsp_o.rem_zero = (rem_q == '0);
endmodule

### design/generation_tagged_block_pool.sv
// ----------------------------------------------------------------------------
// generation_tagged_block_pool
// fixed-size block pool with a lifo free list and per-block generation tags
// ----------------------------------------------------------------------------
// alloc checks, pops the free stack, then bumps the tag, or ends after the
//   checks if rejected; a null free or query answers at once; free and query
//   wait on the divider, then read the tag; retire all walks all 256 blocks
// commands: one at a time, busy high up to and including the result cycle, so
//   the next transfer comes at the earliest in the cycle after a result
// reset: async active low, then a clearing pass with busy high
module generation_tagged_block_pool (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [15:0] req_size_i,
  input  logic [15:0] req_align_i,
  input  logic        addr_null_i,
  input  logic [23:0] byte_offset_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [19:0] block_addr_o,
  output logic [7:0]  block_index_o,
  output logic [31:0] generation_o,
  output logic        live_o,
  output logic [8:0]  free_blocks_o,
  output logic [15:0] double_free_count_o
);
  import gtbp_pkg::*;

  // configuration registers
  logic [12:0] bsize_q;
  logic [8:0]  bcount_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q  <= 13'd64;
      bcount_q <= 9'd256;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgBlockSize) bsize_q <= cfg_data_i;
      else bcount_q <= cfg_data_i[8:0];
    end
  end

  // effective size and count, clamped
  logic [12:0] bs;
  logic [CntW-1:0] bc;
  assign bs = (bsize_q == '0) ? 13'd1 :
              (bsize_q > 13'(MaxBlockBytes)) ? 13'(MaxBlockBytes) : bsize_q;
  assign bc = (bcount_q > 9'(MaxBlocks)) ? CntW'(MaxBlocks) : bcount_q;

  // memories: free stack and generation table
  logic [IdxW-1:0] stk_mem [MaxBlocks];
  logic [31:0]     gen_mem [MaxBlocks];
  logic            stk_we, gen_we;
  logic [IdxW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata_q;
  logic [IdxW-1:0] gen_waddr, gen_raddr;
  logic [31:0]     gen_wdata, gen_rdata_q;

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rdata_q <= stk_mem[stk_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (gen_we) gen_mem[gen_waddr] <= gen_wdata;
    gen_rdata_q <= gen_mem[gen_raddr];
  end

  // shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;
  gtbp_divider u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // command transfer
  logic accept;
  assign accept = start && !busy;

  // sequencer state
  state_e          state_q, state_d;
  logic [1:0]      op_q;
  logic [15:0]     size_q, align_q;
  logic [23:0]     off_q;
  logic [CntW-1:0] depth_q, depth_d;
  logic [15:0]     dfree_q, dfree_d;
  logic [IdxW:0]   walk_q, walk_d;    // retire walk, one extra bit for the end
  logic            clear_q, clear_d;  // first pass after reset zeroes gens
  logic [IdxW-1:0] idx_q, idx_d;
  logic [2:0]      st_q, st_d;
  logic [31:0]     gen_q, gen_d;
  logic            live_q, live_d;
  logic [19:0]     addr_q, addr_d;
  logic            done_q, done_d;

  // alignment check helpers
  logic align_bad;
  logic [16:0] bs_ext;
  assign bs_ext = {4'd0, bs};
  assign align_bad = (align_q == '0) || ((align_q & (align_q - 16'd1)) != '0) ||
                     ((align_q > 16'd1) && ((bs_ext[15:0] & (align_q - 16'd1)) != '0)) ||
                     ((align_q > 16'd1) && ({1'b0, align_q} > bs_ext));

  // free/query range check
  logic [21:0] span;
  logic        in_range;
  assign span     = 22'(bs) * 22'(bc);
  assign in_range = ({2'b0, off_q} < {4'd0, span}) && div_rsp.rem_zero;

  always_comb begin
    state_d   = state_q;
    depth_d   = depth_q;
    dfree_d   = dfree_q;
    walk_d    = walk_q;
    clear_d   = clear_q;
    idx_d     = idx_q;
    st_d      = st_q;
    gen_d     = gen_q;
    live_d    = live_q;
    addr_d    = addr_q;
    done_d    = 1'b0;
    stk_we    = 1'b0;
    stk_waddr = depth_q[IdxW-1:0];
    stk_wdata = idx_q;
    stk_raddr = IdxW'(depth_q - CntW'(1));
    gen_we    = 1'b0;
    gen_waddr = idx_q;
    gen_wdata = gen_rdata_q + 32'd1;
    gen_raddr = idx_q;
    div_req.start    = 1'b0;
    div_req.dividend = off_q;
    div_req.divisor  = bs;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d  = '0;
          st_d   = ST_OK;
          gen_d  = '0;
          live_d = 1'b0;
          addr_d = '0;
          case (op_e'(op_i))
            OP_ALLOC: state_d = S_AREAD;
            OP_FREE, OP_QUERY: begin
              if (addr_null_i) begin
                if (op_e'(op_i) == OP_QUERY) st_d = ST_BAD_ADDR;
                state_d = S_DONE;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = byte_offset_i;
                state_d          = S_DIV;
              end
            end
            default: begin
              walk_d  = '0;
              state_d = S_RETIRE;
            end
          endcase
        end
      end
      S_AREAD: begin
        if ((size_q == '0) || (size_q > {3'd0, bs}) || (depth_q == '0)) begin
          st_d = ST_SIZE; state_d = S_DONE;
        end else if (align_bad) begin
          st_d = ST_ALIGN; state_d = S_DONE;
        end else begin
          state_d = S_AWAIT;
        end
      end
      S_AWAIT: begin
        gen_raddr = stk_rdata_q;
        idx_d     = stk_rdata_q;
        depth_d   = depth_q - CntW'(1);
        state_d   = S_AGEN;
      end
      S_AGEN: begin
        gen_we  = 1'b1;
        gen_d   = gen_rdata_q + 32'd1;
        live_d  = gen_d[0];
        addr_d  = 20'(22'(idx_q) * 22'(bs));
        state_d = S_DONE;
      end
      S_DIV: begin
        gen_raddr = div_rsp.quotient[IdxW-1:0];
        if (div_rsp.done) begin
          if (!in_range) begin
            st_d = ST_BAD_ADDR; state_d = S_DONE;
          end else begin
            idx_d   = div_rsp.quotient[IdxW-1:0];
            state_d = S_FWAIT;
          end
        end
      end
      S_FWAIT: begin
        if (op_e'(op_q) == OP_QUERY) begin
          gen_d = gen_rdata_q; live_d = gen_rdata_q[0]; state_d = S_DONE;
        end else if (!gen_rdata_q[0]) begin
          gen_d = gen_rdata_q; st_d = ST_DBL_FREE;
          if (dfree_q != 16'hFFFF) dfree_d = dfree_q + 16'd1;
          state_d = S_DONE;
        end else begin
          gen_we = 1'b1;
          gen_d  = gen_rdata_q + 32'd1;
          if (depth_q < CntW'(MaxBlocks)) begin
            stk_we  = 1'b1;
            depth_d = depth_q + CntW'(1);
          end
          state_d = S_DONE;
        end
      end
      S_RETIRE: begin
        // read gen of walk index, stack gets descending fill
        gen_raddr = walk_q[IdxW-1:0];
        if (walk_q[IdxW]) begin
          depth_d = bc;
          dfree_d = '0;
          clear_d = 1'b0;
          // the clearing pass after reset gives no result
          state_d = clear_q ? S_IDLE : S_DONE;
        end else begin
          state_d = S_RWAIT;
        end
      end
      S_RWAIT: begin
        gen_we    = 1'b1;
        gen_waddr = walk_q[IdxW-1:0];
        gen_wdata = clear_q ? 32'd0 : gen_rdata_q + {31'd0, gen_rdata_q[0]};
        if (walk_q < (IdxW+1)'(bc)) begin
          stk_we    = 1'b1;
          stk_waddr = IdxW'((IdxW+1)'(bc) - walk_q - (IdxW+1)'(1));
          stk_wdata = walk_q[IdxW-1:0];
        end
        walk_d  = walk_q + (IdxW+1)'(1);
        state_d = S_RETIRE;
      end
      S_DONE: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RETIRE;
      depth_q <= '0;
      dfree_q <= '0;
      walk_q  <= '0;
      clear_q <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      dfree_q <= dfree_d;
      walk_q  <= walk_d;
      clear_q <= clear_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept) begin
      op_q    <= op_i;
      size_q  <= req_size_i;
      align_q <= req_align_i;
      off_q   <= byte_offset_i;
    end
    idx_q  <= idx_d;
    st_q   <= st_d;
    gen_q  <= gen_d;
    live_q <= live_d;
    addr_q <= addr_d;
  end

  assign busy                = (state_q != S_IDLE) || done_q;
  assign done_o              = done_q;
  assign status_o            = st_q;
  assign block_addr_o        = addr_q;
  assign block_index_o       = (st_q == ST_BAD_ADDR) ? '0 : idx_q;
  assign generation_o        = gen_q;
  assign live_o              = live_q;
  assign free_blocks_o       = depth_q;
  assign double_free_count_o = dfree_q;
endmodule

### design/gtbp_checker.sv
// ----------------------------------------------------------------------------
// gtbp_checker
// port-level checks on the block pool
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module gtbp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [2:0] status_o,
  input logic [8:0] free_blocks_o
);
  `GTBP_ASSERT(a_done_busy, clk_i, rst_ni, done_o |-> busy, "result while not busy")
  `GTBP_ASSERT(a_no_double_done, clk_i, rst_ni, done_o |=> !done_o, "result repeated")
  `GTBP_ASSERT(a_status_range, clk_i, rst_ni, done_o |-> (status_o <= 3'd4), "bad status")
  `GTBP_ASSERT(a_depth_range, clk_i, rst_ni, done_o |-> (free_blocks_o <= 9'd256), "bad depth")
  `GTBP_ASSERT_ONEHOT0(a_start_done, clk_i, rst_ni, {start && !busy, done_o}, "accept with result")
endmodule

bind generation_tagged_block_pool gtbp_checker u_gtbp_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .status_o, .free_blocks_o
);

### verif/pool_checker.sv
// ----------------------------------------------------------------------------
// pool_checker
// watches the command, configuration and result channels of the block pool,
// predicts every result from its own copy of the pool state and compares
// ----------------------------------------------------------------------------
module pool_checker
  import gtbp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  op_i,
  input  logic [15:0] req_size_i,
  input  logic [15:0] req_align_i,
  input  logic        addr_null_i,
  input  logic [23:0] byte_offset_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        done_o,
  input  logic [2:0]  status_o,
  input  logic [19:0] block_addr_o,
  input  logic [7:0]  block_index_o,
  input  logic [31:0] generation_o,
  input  logic        live_o,
  input  logic [8:0]  free_blocks_o,
  input  logic [15:0] double_free_count_o,
  output int          pending_o,
  output int          errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [19:0] addr;
    logic [7:0]  idx;
    logic [31:0] gen;
    logic        live;
    logic [8:0]  free;
    logic [15:0] dfc;
  } pool_result_t;

  logic [12:0] size_reg;
  logic [8:0]  count_reg;
  logic [7:0]  free_list [MaxBlocks];
  int          list_depth;
  logic [31:0] gen_tag [MaxBlocks];
  logic [15:0] dbl_frees;
  pool_result_t awaited [$];
  int          errors;

  assign errors_o  = errors;

  function automatic int unsigned eff_size();
    if (size_reg == 0) return 1;
    if (size_reg > MaxBlockBytes) return MaxBlockBytes;
    return size_reg;
  endfunction

  function automatic int unsigned eff_count();
    return (count_reg > MaxBlocks) ? MaxBlocks : count_reg;
  endfunction

  function automatic void refill_free_list();
    int unsigned n;
    n = eff_count();
    for (int unsigned i = 0; i < n; i++) free_list[i] = 8'(n - 1 - i);
    list_depth = n;
  endfunction

  // offset to block index, 0 on a bad address
  function automatic bit find_block(logic [23:0] offset, output logic [7:0] idx);
    longint unsigned bs, span;
    bs   = eff_size();
    span = bs * eff_count();
    idx  = '0;
    if (offset >= span) return 0;
    if ((offset % bs) != 0) return 0;
    idx = 8'(offset / bs);
    return 1;
  endfunction

  function automatic pool_result_t pool_outcome(op_e op, logic [15:0] size,
                                                logic [15:0] align, logic is_null,
                                                logic [23:0] offset);
    pool_result_t r;
    int unsigned  bs;
    logic [7:0]   idx;
    r  = '0;
    bs = eff_size();
    case (op)
      OP_ALLOC: begin
        if (size == 0 || size > bs || list_depth == 0) begin
          r.status = ST_SIZE;
        end else if (align == 0 || (align & (align - 16'd1)) != 0 ||
                     (align > 1 && (bs % align) != 0)) begin
          r.status = ST_ALIGN;
        end else begin
          list_depth--;
          idx = free_list[list_depth % MaxBlocks];
          gen_tag[idx] = gen_tag[idx] + 32'd1;
          r.idx  = idx;
          r.gen  = gen_tag[idx];
          r.live = gen_tag[idx][0];
          r.addr = 20'(idx * bs);
        end
      end
      OP_FREE: begin
        if (!is_null) begin
          if (!find_block(offset, idx)) begin
            r.status = ST_BAD_ADDR;
          end else if (!gen_tag[idx][0]) begin
            if (dbl_frees != 16'hFFFF) dbl_frees++;
            r.status = ST_DBL_FREE;
            r.idx    = idx;
            r.gen    = gen_tag[idx];
          end else begin
            gen_tag[idx] = gen_tag[idx] + 32'd1;
            r.idx = idx;
            r.gen = gen_tag[idx];
            if (list_depth < MaxBlocks) begin
              free_list[list_depth] = idx;
              list_depth++;
            end
          end
        end
      end
      OP_QUERY: begin
        if (is_null || !find_block(offset, idx)) begin
          r.status = ST_BAD_ADDR;
        end else begin
          r.idx  = idx;
          r.gen  = gen_tag[idx];
          r.live = gen_tag[idx][0];
        end
      end
      default: begin
        // retire all: live blocks go even, list rebuilt, count cleared
        for (int i = 0; i < MaxBlocks; i++) gen_tag[i] = gen_tag[i] + gen_tag[i][0];
        dbl_frees = '0;
        refill_free_list();
      end
    endcase
    r.free = 9'(list_depth);
    r.dfc  = dbl_frees;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pool_result_t got, want;
    if (!rst_ni) begin
      size_reg  = 13'd64;
      count_reg = 9'd256;
      for (int i = 0; i < MaxBlocks; i++) begin
        gen_tag[i]   = '0;
        free_list[i] = '0;
      end
      dbl_frees = '0;
      refill_free_list();
      awaited.delete();
      errors = 0;
      pending_o = 0;
    end else begin
      if (done_o) begin
        got = '{status_o, block_addr_o, block_index_o, generation_o, live_o,
                free_blocks_o, double_free_count_o};
        if (awaited.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: %p", got);
        end else begin
          want = awaited.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch status %0d/%0d addr %0h/%0h idx %0d/%0d gen %0h/%0h",
                       want.status, got.status, want.addr, got.addr, want.idx,
                       got.idx, want.gen, got.gen);
              $display("         live %0d/%0d free %0d/%0d dfc %0d/%0d", want.live,
                       got.live, want.free, got.free, want.dfc, got.dfc);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgBlockSize) size_reg = cfg_data_i;
        else count_reg = cfg_data_i[8:0];
      end
      if (start && !busy) begin
        want = pool_outcome(op_e'(op_i), req_size_i, req_align_i,
                            addr_null_i, byte_offset_i);
        awaited = {awaited, want};
      end
      pending_o = awaited.size();
    end
  end
endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives directed and random pool commands through several configurations;
// a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
  import gtbp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  op_i = '0;
  logic [15:0] req_size_i = '0;
  logic [15:0] req_align_i = '0;
  logic        addr_null_i = 1'b0;
  logic [23:0] byte_offset_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [12:0] cfg_data_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [19:0] block_addr_o;
  logic [7:0]  block_index_o;
  logic [31:0] generation_o;
  logic        live_o;
  logic [8:0]  free_blocks_o;
  logic [15:0] double_free_count_o;
  int          pending;
  int          errors;

  // current effective geometry, used to aim commands at real blocks
  int unsigned cur_bs = 64;
  int unsigned cur_cnt = 256;
  int          burst_left = 0;

  generation_tagged_block_pool dut (.*);

  pool_checker u_checker (.*, .pending_o(pending), .errors_o(errors));

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // generous limit: retire passes dominate the slowest run
  initial begin
    #60ms;
    $display("FAIL");
    $finish;
  end

  // one command transfer, with burst-shaped gaps in front of it
  task automatic issue(op_e op, logic [15:0] size, logic [15:0] align,
                       logic is_null, logic [23:0] offset);
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    op_i = op;
    req_size_i = size;
    req_align_i = align;
    addr_null_i = is_null;
    byte_offset_i = offset;
    start = 1'b1;
    // busy only moves at rising edges, so its value here holds for the next edge
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [12:0] data);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    while (!cfg_ready_o) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_geometry(logic [12:0] bs, logic [8:0] cnt);
    wait_idle();
    write_reg(CfgBlockSize, bs);
    // upper data bits are ignored for the count register
    write_reg(CfgBlockCount, {4'($urandom), cnt});
    cur_bs = (bs == 0) ? 1 : (bs > MaxBlockBytes ? MaxBlockBytes : bs);
    cur_cnt = (cnt > MaxBlocks) ? MaxBlocks : cnt;
    issue(OP_RETIRE, '0, '0, 1'b0, '0);
  endtask

  task automatic random_cmd();
    int unsigned pick, k;
    logic [23:0] off;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, 12);
    off = (cur_cnt == 0) ? 24'd0 : 24'($urandom_range(0, cur_cnt - 1) * cur_bs);
    if (pick < 38) begin
      issue(OP_ALLOC, 16'($urandom_range(1, cur_bs)), 16'(1 << k), 1'b0, 24'($urandom));
    end else if (pick < 70) begin
      issue(OP_FREE, 16'($urandom), 16'($urandom), 1'b0, off);
    end else if (pick < 88) begin
      issue(OP_QUERY, 16'($urandom), 16'($urandom), 1'b0, off);
    end else if (pick < 98) begin
      // noise: random field values, op limited to alloc, free and query
      issue(op_e'($urandom_range(0, 2)), 16'($urandom), 16'($urandom),
            1'($urandom), 24'($urandom));
    end else begin
      issue(OP_RETIRE, 16'($urandom), 16'($urandom), 1'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    logic [12:0] sizes [10];
    logic [8:0]  counts [10];
    sizes  = '{13'd64, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd48, 13'd3, 13'd1000,
               13'd128, 13'd16};
    counts = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd7, 9'd200, 9'd32, 9'd256, 9'd100, 9'd2};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset geometry of 64-byte blocks, 256 of them
    issue(OP_ALLOC, 16'd0, 16'd1, 1'b0, '0);
    issue(OP_ALLOC, 16'hFFFF, 16'd1, 1'b0, '0);
    issue(OP_ALLOC, 16'd64, 16'd0, 1'b0, '0);
    issue(OP_ALLOC, 16'd8, 16'd3, 1'b0, '0);
    issue(OP_ALLOC, 16'd8, 16'd128, 1'b0, '0);
    issue(OP_ALLOC, 16'd8, 16'h8000, 1'b0, '0);
    issue(OP_ALLOC, 16'd64, 16'd64, 1'b0, '0);
    issue(OP_ALLOC, 16'd1, 16'd1, 1'b0, '0);
    issue(OP_FREE, '0, '0, 1'b1, 24'd0);
    issue(OP_QUERY, '0, '0, 1'b1, 24'd0);
    issue(OP_QUERY, '0, '0, 1'b0, 24'd0);
    issue(OP_FREE, '0, '0, 1'b0, 24'd0);
    issue(OP_FREE, '0, '0, 1'b0, 24'd0);
    issue(OP_FREE, '0, '0, 1'b0, 24'd1);
    issue(OP_FREE, '0, '0, 1'b0, 24'd16384);
    issue(OP_QUERY, '0, '0, 1'b0, 24'hFFFFFF);
    issue(OP_QUERY, '0, '0, 1'b0, 24'd16320);
    issue(OP_RETIRE, '0, '0, 1'b0, '0);
    issue(OP_QUERY, '0, '0, 1'b0, 24'd64);
    // empty pool
    set_geometry(13'd4096, 9'd0);
    issue(OP_ALLOC, 16'd1, 16'd1, 1'b0, '0);
    issue(OP_FREE, '0, '0, 1'b0, 24'd0);

    // random phases over a range of geometries, extremes included
    for (int p = 0; p < 10; p++) begin
      set_geometry(sizes[p], counts[p]);
      repeat (200) random_cmd();
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
